### rtl/assert_macros.svh
// Assertion macros used by bmpycc_checker.sv, the checker of this block.
// Holds concurrent assertion wrappers only; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock edge.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### rtl/bmpycc_pkg.sv
// Shared types and constants for the BMP to YCbCr 4:2:2 converter.
// No dependencies; imported by the front end, queue, back end and top level.
`default_nettype none

package bmpycc_pkg;

   // Pixel format register codes
   typedef enum logic [2:0] {
      FMT_1BPP  = 3'd0,
      FMT_4BPP  = 3'd1,
      FMT_8BPP  = 3'd2,
      FMT_24BPP = 3'd3,
      FMT_32BPP = 3'd4
   } fmt_type;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_FORMAT = 2'd0,
      CSR_WIDTH  = 2'd1,
      CSR_HEIGHT = 2'd2,
      CSR_UNUSED = 2'd3
   } csr_index_type;

   typedef enum logic {
      JOB_PAL_WRITE = 1'b0,
      JOB_PAIR      = 1'b1
   } job_kind_type;

   // One unit of work for the conversion back end
   typedef struct packed {
      job_kind_type kind;
      logic         use_pal;   // c1/c2 hold palette indexes in [7:0]
      logic [23:0]  c1;        // color R,G,B or palette index; write data for palette
      logic [23:0]  c2;        // second color or index; palette address on writes
      logic [8:0]   row_top;   // row number counted from the top
      logic [9:0]   col_half;  // word column within the row
      logic         last;
      logic         done;
   } job_type;

   localparam logic [3:0] GROUP_DEPTH = 4'd8;
   localparam int         FIFO_DEPTH  = 4;

   // Reset values of the configuration registers
   localparam logic [2:0] FORMAT_RESET = 3'd3;
   localparam logic [9:0] WIDTH_RESET  = 10'd640;
   localparam logic [8:0] HEIGHT_RESET = 9'd480;

   // Conversion weights
   localparam logic [9:0]  Y_R = 10'd299;
   localparam logic [9:0]  Y_G = 10'd587;
   localparam logic [9:0]  Y_B = 10'd114;
   localparam logic [25:0] C_OFFSET = 26'd12800000;
   localparam logic [15:0] C_HALF   = 16'd50000;
   localparam logic [15:0] CB_R     = 16'd16874;
   localparam logic [15:0] CB_G     = 16'd33126;
   localparam logic [15:0] CR_G     = 16'd41869;
   localparam logic [15:0] CR_B     = 16'd8131;

   // Exact reciprocals: n/1000 for n < 2^18, n/100000 for n < 2^25
   localparam logic [18:0] Y_RECIP = 19'd268436;
   localparam int          Y_SHIFT = 28;
   localparam logic [25:0] C_RECIP = 26'd43980466;
   localparam int          C_SHIFT = 42;

endpackage

`default_nettype wire

### rtl/bmpycc_fifo.sv
// Four-entry job queue between the byte front end and the conversion back end.
// Depends on bmpycc_pkg for the job type.
`default_nettype none

module bmpycc_fifo
   import bmpycc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   output logic         full,
   input  wire logic    pop,
   output job_type      head_job,
   output logic         empty
);

   localparam int PW = $clog2(FIFO_DEPTH);

   job_type          slot_ff [FIFO_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PW:0]      count_ff, count_in;

   assign full     = (count_ff == (PW+1)'(FIFO_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_job = slot_ff[rd_ptr_ff];

   // pointer and fill tracking
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push && !full) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop && !empty) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if ((push && !full) && !(pop && !empty)) begin
         count_in = count_ff + 1'b1;
      end else if (!(push && !full) && (pop && !empty)) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push && !full) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

### rtl/bmpycc_front.sv
// Front end: config registers, input beat acceptance, row/column/pad tracking,
// byte grouping, one job per cycle unless the queue is full; uses bmpycc_pkg.
`default_nettype none

module bmpycc_front
   import bmpycc_pkg::*;
#(
   parameter int MAX_WIDTH  = 640,
   parameter int MAX_HEIGHT = 480
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic       req_action,
   input  wire logic [7:0] req_palette_index,
   input  wire logic [7:0] req_palette_red,
   input  wire logic [7:0] req_palette_green,
   input  wire logic [7:0] req_palette_blue,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [1:0] csr_index,
   input  wire logic [9:0] csr_data,
   output logic            job_push,
   output job_type         job_out,
   input  wire logic       job_full,
   output logic [9:0]      half_width
);

   localparam logic [9:0] MAX_W = 10'((MAX_WIDTH > 1023) ? 1023 : MAX_WIDTH);
   localparam logic [8:0] MAX_H = 9'((MAX_HEIGHT > 511) ? 511 : MAX_HEIGHT);

   // configuration
   logic [2:0] fmt_ff;
   logic [9:0] width_ff;
   logic [8:0] height_ff;
   logic       csr_write;
   logic       csr_restart;
   logic [9:0] w_eff;
   logic [8:0] h_eff;
   logic [10:0] w_sum;

   // image position
   logic [9:0] col_ff, col_in;
   logic [8:0] row_ff, row_in;
   logic [1:0] pad_ff, pad_in;
   logic [2:0] gc_ff, gc_in;
   logic [7:0] group_ff [8];
   logic [7:0] group_in [8];

   // issue stage
   logic       pend_valid_ff, pend_valid_in;
   logic       pend_serial_ff;
   logic [7:0] pend_byte_ff;
   logic [3:0] pend_cnt_ff;
   logic [9:0] pend_col_ff;
   logic       pend_lastrow_ff;
   logic [1:0] pend_k_ff, pend_klast_ff;
   job_type    pend_job_ff;

   logic       load;
   logic       load_serial;
   job_type    load_job;
   logic [3:0] load_cnt;

   logic       accept;
   logic       issue_last;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   // only writes to a defined register restart the image
   assign csr_restart = csr_write && (csr_index_type'(csr_index) != CSR_UNUSED);

   // clamp width and height to legal range
   always_comb begin
      w_eff = width_ff;
      if (width_ff == '0) begin
         w_eff = 10'd1;
      end else if (width_ff > MAX_W) begin
         w_eff = MAX_W;
      end
      h_eff = height_ff;
      if (height_ff == '0) begin
         h_eff = 9'd1;
      end else if (height_ff > MAX_H) begin
         h_eff = MAX_H;
      end
      w_sum      = {1'b0, w_eff} + 11'd1;
      half_width = w_sum[10:1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff    <= FORMAT_RESET;
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_FORMAT: fmt_ff    <= csr_data[2:0];
            CSR_WIDTH:  width_ff  <= csr_data;
            CSR_HEIGHT: height_ff <= csr_data[8:0];
            default:    ;
         endcase
      end
   end

   // job issue from the pending beat, one per cycle while the queue is not full
   logic [1:0]  k;
   logic        bit1, bit2;
   logic [10:0] reach;

   always_comb begin
      k          = pend_k_ff;
      bit1       = pend_byte_ff[3'd7 - {k, 1'b0}];
      bit2       = ({1'b0, k, 1'b1} < pend_cnt_ff) ? pend_byte_ff[3'd6 - {k, 1'b0}] : bit1;
      reach      = {1'b0, pend_col_ff} + {8'd0, k, 1'b0} + 11'd2;
      issue_last = (k == pend_klast_ff);
      job_out    = pend_job_ff;
      if (pend_serial_ff) begin
         job_out.c1       = {23'd0, bit1};
         job_out.c2       = {23'd0, bit2};
         job_out.col_half = pend_job_ff.col_half + {8'd0, k};
         job_out.done     = pend_lastrow_ff && (reach >= {1'b0, w_eff});
         job_out.last     = issue_last;
      end
      job_push  = pend_valid_ff && !job_full;
   end

   assign req_stall = pend_valid_ff && !(job_push && issue_last);
   assign accept    = req_valid && !req_stall;

   // classify the accepted beat and advance the image position
   logic [9:0]  rem;
   logic        two_px;
   logic [3:0]  bpp;
   logic [3:0]  need;
   logic [3:0]  gc_inc;
   logic [10:0] col_ext;
   logic        last_row;
   logic [1:0]  rb;
   logic [1:0]  pad_need;
   logic [10:0] rb_sum;

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      pad_in  = pad_ff;
      gc_in   = gc_ff;
      group_in = group_ff;
      load        = 1'b0;
      load_serial = 1'b0;
      load_cnt    = 4'd1;
      load_job          = '0;
      load_job.kind     = JOB_PAIR;
      load_job.use_pal  = 1'b1;
      load_job.row_top  = h_eff - 9'd1 - row_ff;
      load_job.col_half = {1'b0, col_ff[9:1]};
      load_job.last     = 1'b1;
      rem      = w_eff - col_ff;
      two_px   = (rem >= 10'd2);
      last_row = ({1'b0, row_ff} + 10'd1) == {1'b0, h_eff};
      bpp      = 4'd1;
      need     = 4'd1;
      gc_inc   = {1'b0, gc_ff} + 4'd1;
      col_ext  = '0;
      rb       = '0;
      rb_sum   = '0;
      pad_need = '0;

      if (accept && !req_action) begin
         load          = 1'b1;
         load_job.kind = JOB_PAL_WRITE;
         load_job.c1   = {req_palette_red, req_palette_green, req_palette_blue};
         load_job.c2   = {16'd0, req_palette_index};
      end else if (accept && fmt_ff <= FMT_32BPP) begin
         if (col_ff >= w_eff) begin
            pad_in = pad_ff + 2'd1;
         end else begin
            case (fmt_ff)
               FMT_1BPP: begin
                  load        = 1'b1;
                  load_serial = 1'b1;
                  load_cnt    = (rem > 10'd8) ? 4'd8 : rem[3:0];
                  col_in      = col_ff + {6'd0, load_cnt};
               end
               FMT_4BPP: begin
                  load        = 1'b1;
                  load_job.c1 = {20'd0, req_data_byte[7:4]};
                  load_job.c2 = two_px ? {20'd0, req_data_byte[3:0]}
                                       : {20'd0, req_data_byte[7:4]};
                  col_in      = col_ff + (two_px ? 10'd2 : 10'd1);
                  load_job.done = last_row && (col_in >= w_eff);
               end
               default: begin
                  bpp  = (fmt_ff == FMT_8BPP) ? 4'd1 : (fmt_ff == FMT_24BPP) ? 4'd3 : 4'd4;
                  need = two_px ? {bpp[2:0], 1'b0} : bpp;
                  group_in[gc_ff] = req_data_byte;
                  gc_in = gc_inc[2:0];
                  if (gc_inc == need) begin
                     load  = 1'b1;
                     gc_in = '0;
                     col_in = col_ff + (two_px ? 10'd2 : 10'd1);
                     load_job.done = last_row && (col_in >= w_eff);
                     if (fmt_ff == FMT_8BPP) begin
                        load_job.c1 = {16'd0, group_in[0]};
                        load_job.c2 = two_px ? {16'd0, group_in[1]} : {16'd0, group_in[0]};
                     end else begin
                        load_job.use_pal = 1'b0;
                        load_job.c1 = {group_in[2], group_in[1], group_in[0]};
                        if (!two_px) begin
                           load_job.c2 = load_job.c1;
                        end else if (fmt_ff == FMT_24BPP) begin
                           load_job.c2 = {group_in[5], group_in[4], group_in[3]};
                        end else begin
                           load_job.c2 = {group_in[6], group_in[5], group_in[4]};
                        end
                     end
                  end
               end
            endcase
         end

         // end of row: wait for padding to a multiple of four bytes
         col_ext = {1'b0, col_in};
         if (col_ext >= {1'b0, w_eff}) begin
            case (fmt_ff)
               FMT_1BPP: begin
                  rb_sum = {1'b0, w_eff} + 11'd7;
                  rb     = rb_sum[4:3];
               end
               FMT_4BPP: begin
                  rb_sum = {1'b0, w_eff} + 11'd1;
                  rb     = rb_sum[2:1];
               end
               FMT_8BPP:  rb = w_eff[1:0];
               FMT_24BPP: rb = w_eff[1:0] + {w_eff[0], 1'b0};
               default:   rb = 2'd0;
            endcase
            pad_need = 2'd0 - rb;
            if (pad_in >= pad_need) begin
               col_in = '0;
               pad_in = '0;
               gc_in  = '0;
               row_in = last_row ? 9'd0 : row_ff + 9'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || csr_restart) begin
         col_ff <= '0;
         row_ff <= '0;
         pad_ff <= '0;
         gc_ff  <= '0;
         for (int i = 0; i < 8; i++) begin
            group_ff[i] <= '0;
         end
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         pad_ff   <= pad_in;
         gc_ff    <= gc_in;
         group_ff <= group_in;
      end
   end

   // pending beat register
   always_comb begin
      pend_valid_in = pend_valid_ff;
      if (load) begin
         pend_valid_in = 1'b1;
      end else if (job_push && issue_last) begin
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         pend_k_ff     <= '0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         if (load) begin
            pend_k_ff <= '0;
         end else if (job_push) begin
            pend_k_ff <= pend_k_ff + 2'd1;
         end
      end
   end

   logic [3:0] cnt_less;
   assign cnt_less = load_cnt - 4'd1;

   always_ff @(posedge clock) begin
      if (load) begin
         pend_serial_ff  <= load_serial;
         pend_byte_ff    <= req_data_byte;
         pend_cnt_ff     <= load_cnt;
         pend_col_ff     <= col_ff;
         pend_lastrow_ff <= last_row;
         pend_klast_ff   <= cnt_less[2:1];
         pend_job_ff     <= load_job;
      end
   end

endmodule

`default_nettype wire

### rtl/bmpycc_back.sv
// Back end: palette memory, pair color conversion, chroma averaging, packing
// and the result register. Depends on bmpycc_pkg.
`default_nettype none

module bmpycc_back
   import bmpycc_pkg::*;
#(
   parameter int PALETTE_DEPTH = 256
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire job_type    head_job,
   input  wire logic       head_empty,
   output logic            pop,
   input  wire logic [9:0] half_width,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [31:0]     rsp_pixel_pair,
   output logic [17:0]     rsp_word_index,
   output logic            rsp_last_of_run,
   output logic            rsp_image_done
);

   localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
   localparam logic [8:0] DEPTH9 = 9'(PALETTE_DEPTH);

   logic adv;
   logic [23:0] pal_mem [PALETTE_DEPTH];

   assign adv = !rsp_valid || !rsp_stall;
   assign pop = adv && !head_empty;

   // stage 1: palette access and row base
   logic        oob1, oob2, oobw;
   logic        s1_valid_ff;
   logic        s1_pal_ff, s1_oob1_ff, s1_oob2_ff;
   logic [23:0] s1_raw1_ff, s1_raw2_ff;
   logic [23:0] s1_rd1_ff, s1_rd2_ff;
   logic [17:0] s1_base_ff;
   logic [9:0]  s1_colh_ff;
   logic        s1_last_ff, s1_done_ff;
   logic [18:0] base_prod;

   assign oob1 = {1'b0, head_job.c1[7:0]} >= DEPTH9;
   assign oob2 = {1'b0, head_job.c2[7:0]} >= DEPTH9;
   assign oobw = {1'b0, head_job.c2[7:0]} >= DEPTH9;
   assign base_prod = 19'(head_job.row_top) * 19'(half_width);

   always_ff @(posedge clock) begin
      if (pop) begin
         if (head_job.kind == JOB_PAL_WRITE && !oobw) begin
            pal_mem[head_job.c2[AW-1:0]] <= head_job.c1;
         end
         s1_rd1_ff <= pal_mem[head_job.c1[AW-1:0]];
         s1_rd2_ff <= pal_mem[head_job.c2[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_pal_ff  <= head_job.use_pal;
         s1_oob1_ff <= oob1;
         s1_oob2_ff <= oob2;
         s1_raw1_ff <= head_job.c1;
         s1_raw2_ff <= head_job.c2;
         s1_base_ff <= base_prod[17:0];
         s1_colh_ff <= head_job.col_half;
         s1_last_ff <= head_job.last;
         s1_done_ff <= head_job.done;
      end
   end

   // stage 2: weighted sums per pixel
   logic [23:0] col1, col2;
   logic [17:0] y1_n, y2_n;
   logic [25:0] cb1_n, cb2_n, cr1_n, cr2_n;
   logic        s2_valid_ff;
   logic [17:0] s2_y1_ff, s2_y2_ff;
   logic [24:0] s2_cb1_ff, s2_cb2_ff, s2_cr1_ff, s2_cr2_ff;
   logic [17:0] s2_idx_ff;
   logic        s2_last_ff, s2_done_ff;

   function automatic logic [17:0] luma_sum(input logic [23:0] c);
      return 18'(c[23:16]) * 18'(Y_R) + 18'(c[15:8]) * 18'(Y_G) + 18'(c[7:0]) * 18'(Y_B);
   endfunction

   function automatic logic [25:0] cb_sum(input logic [23:0] c);
      return C_OFFSET + 26'(c[7:0]) * 26'(C_HALF) - 26'(c[23:16]) * 26'(CB_R)
             - 26'(c[15:8]) * 26'(CB_G);
   endfunction

   function automatic logic [25:0] cr_sum(input logic [23:0] c);
      return C_OFFSET + 26'(c[23:16]) * 26'(C_HALF) - 26'(c[15:8]) * 26'(CR_G)
             - 26'(c[7:0]) * 26'(CR_B);
   endfunction

   always_comb begin
      col1 = s1_pal_ff ? (s1_oob1_ff ? 24'd0 : s1_rd1_ff) : s1_raw1_ff;
      col2 = s1_pal_ff ? (s1_oob2_ff ? 24'd0 : s1_rd2_ff) : s1_raw2_ff;
      y1_n  = luma_sum(col1);
      y2_n  = luma_sum(col2);
      cb1_n = cb_sum(col1);
      cb2_n = cb_sum(col2);
      cr1_n = cr_sum(col1);
      cr2_n = cr_sum(col2);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_y1_ff   <= y1_n;
         s2_y2_ff   <= y2_n;
         s2_cb1_ff  <= cb1_n[24:0];
         s2_cb2_ff  <= cb2_n[24:0];
         s2_cr1_ff  <= cr1_n[24:0];
         s2_cr2_ff  <= cr2_n[24:0];
         s2_idx_ff  <= s1_base_ff + 18'(s1_colh_ff);
         s2_last_ff <= s1_last_ff;
         s2_done_ff <= s1_done_ff;
      end
   end

   // stage 3: divide by reciprocal multiplication
   logic [36:0] y1_p, y2_p;
   logic [50:0] cb1_p, cb2_p, cr1_p, cr2_p;
   logic        s3_valid_ff;
   logic [7:0]  s3_y1_ff, s3_y2_ff, s3_cb1_ff, s3_cb2_ff, s3_cr1_ff, s3_cr2_ff;
   logic [17:0] s3_idx_ff;
   logic        s3_last_ff, s3_done_ff;

   always_comb begin
      y1_p  = 37'(s2_y1_ff) * 37'(Y_RECIP);
      y2_p  = 37'(s2_y2_ff) * 37'(Y_RECIP);
      cb1_p = 51'(s2_cb1_ff) * 51'(C_RECIP);
      cb2_p = 51'(s2_cb2_ff) * 51'(C_RECIP);
      cr1_p = 51'(s2_cr1_ff) * 51'(C_RECIP);
      cr2_p = 51'(s2_cr2_ff) * 51'(C_RECIP);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_y1_ff   <= y1_p[Y_SHIFT +: 8];
         s3_y2_ff   <= y2_p[Y_SHIFT +: 8];
         s3_cb1_ff  <= cb1_p[C_SHIFT +: 8];
         s3_cb2_ff  <= cb2_p[C_SHIFT +: 8];
         s3_cr1_ff  <= cr1_p[C_SHIFT +: 8];
         s3_cr2_ff  <= cr2_p[C_SHIFT +: 8];
         s3_idx_ff  <= s2_idx_ff;
         s3_last_ff <= s2_last_ff;
         s3_done_ff <= s2_done_ff;
      end
   end

   // output stage: chroma average and pack
   logic [8:0] cb_avg, cr_avg;
   logic       rsp_valid_ff;

   assign cb_avg = {1'b0, s3_cb1_ff} + {1'b0, s3_cb2_ff};
   assign cr_avg = {1'b0, s3_cr1_ff} + {1'b0, s3_cr2_ff};

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_pixel_pair  <= {s3_y1_ff, cb_avg[8:1], s3_y2_ff, cr_avg[8:1]};
         rsp_word_index  <= s3_idx_ff;
         rsp_last_of_run <= s3_last_ff;
         rsp_image_done  <= s3_done_ff;
      end
   end

   // valid bits of the stages
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= pop && (head_job.kind == JOB_PAIR);
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

### rtl/bmp_pixels_to_ycbycr_top.sv
// BMP pixel array to packed YCbCr 4:2:2 converter, top level.
// Instantiates bmpycc_front, bmpycc_fifo and bmpycc_back; uses bmpycc_pkg.
`default_nettype none

// Load the palette with action 0 beats, then stream the bottom-up pixel array
// bytes (padding included) with action 1. A byte is taken once the jobs of
// the byte before it have entered the queue; a 1bpp byte makes up to four
// output words. The conversion back end retires one word per cycle, unless
// the output stalls, through a four-stage pipeline (palette read, weighted
// sums, reciprocal multiply, average and pack). A four-entry queue parts the
// byte front end from the back end. Writes to a defined configuration
// register restart the image; the port always accepts, so issue them only
// while no beat is in flight.
module bmp_pixels_to_ycbycr_top
   import bmpycc_pkg::*;
#(
   parameter int MAX_WIDTH     = 640,
   parameter int MAX_HEIGHT    = 480,
   parameter int PALETTE_DEPTH = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_action,
   input  wire logic [7:0]  req_palette_index,
   input  wire logic [7:0]  req_palette_red,
   input  wire logic [7:0]  req_palette_green,
   input  wire logic [7:0]  req_palette_blue,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_pixel_pair,
   output logic [17:0]      rsp_word_index,
   output logic             rsp_last_of_run,
   output logic             rsp_image_done,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [9:0]  csr_data
);

   job_type    push_job, head_job;
   logic       job_push, job_full, job_pop, job_empty;
   logic [9:0] half_width;

   bmpycc_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_palette_index (req_palette_index),
      .req_palette_red   (req_palette_red),
      .req_palette_green (req_palette_green),
      .req_palette_blue  (req_palette_blue),
      .req_data_byte     (req_data_byte),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .job_push          (job_push),
      .job_out           (push_job),
      .job_full          (job_full),
      .half_width        (half_width)
   );

   bmpycc_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (push_job),
      .full     (job_full),
      .pop      (job_pop),
      .head_job (head_job),
      .empty    (job_empty)
   );

   bmpycc_back #(
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head_job        (head_job),
      .head_empty      (job_empty),
      .pop             (job_pop),
      .half_width      (half_width),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_pair  (rsp_pixel_pair),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_image_done  (rsp_image_done)
   );

endmodule

`default_nettype wire

### rtl/bmpycc_checker.sv
// Port-level checks for the converter top level, bound into it below.
// Depends on assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module bmpycc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [31:0] rsp_pixel_pair,
   input wire logic [17:0] rsp_word_index,
   input wire logic        rsp_last_of_run,
   input wire logic        rsp_image_done,
   input wire logic        csr_ready
);

   // the final word of an image closes the run of its byte
   `ASSERT_IMPLY(a_done_is_last, clock, reset, rsp_valid && rsp_image_done, rsp_last_of_run)

   // a stalled result beat holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_pixel_pair) && $stable(rsp_word_index))

   // reset leaves no result pending and the input open
   `ASSERT_NEXT(a_reset_clear, clock, 1'b0, reset, !rsp_valid && !req_stall)

   // configuration writes are never refused
   `ASSERT_IMPLY(a_csr_open, clock, reset, 1'b1, csr_ready)

endmodule

bind bmp_pixels_to_ycbycr_top bmpycc_checker u_checker (.*);

`default_nettype wire
